>>> design/ntwg_pkg.sv
// Shared widths, register index codes and reset values for the NTT twiddle generator.
package ntwg_pkg;

    localparam int unsigned RES_W   = 31;
    localparam int unsigned FAC_W   = 32;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CNT_W   = 5;

    localparam logic [CFG_IDX_W-1:0] REG_FORWARD_ROOT      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INVERSE_ROOT      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS           = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MONTGOMERY_FACTOR = 2'd3;

    localparam logic [RES_W-1:0] FORWARD_ROOT_RST      = 31'd1;
    localparam logic [RES_W-1:0] INVERSE_ROOT_RST      = 31'd1;
    localparam logic [RES_W-1:0] MODULUS_RST           = 31'd12289;
    localparam logic [FAC_W-1:0] MONTGOMERY_FACTOR_RST = 32'd262144;

endpackage

>>> design/ntwg_mulmod.sv
// Bit-serial shift-add modular multiplier: a * b mod q, one bit of a per cycle.
module ntwg_mulmod
    import ntwg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [FAC_W-1:0] a,
    input  logic [RES_W-1:0] b,
    input  logic [RES_W-1:0] q,
    output logic             done,
    output logic [RES_W-1:0] product
);

    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [FAC_W-1:0] a_reg;
    logic [FAC_W-1:0] a_next;
    logic [RES_W-1:0] b_reg;
    logic [RES_W-1:0] b_next;
    logic [RES_W-1:0] acc_reg;
    logic [RES_W-1:0] acc_next;

    logic [RES_W:0] q_ext;
    logic [RES_W:0] dbl;
    logic [RES_W:0] red1;
    logic [RES_W:0] sum;
    logic [RES_W:0] red2;

    always_comb
    begin
        q_ext = {1'b0, q};
        dbl   = {acc_reg, 1'b0};
        red1  = (dbl >= q_ext) ? (dbl - q_ext) : dbl;
        sum   = red1 + (a_reg[FAC_W-1] ? {1'b0, b_reg} : '0);
        red2  = (sum >= q_ext) ? (sum - q_ext) : sum;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            a_next    = a;
            b_next    = b;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            acc_next = red2[RES_W-1:0];
            a_next   = {a_reg[FAC_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == {CNT_W{1'b1}})
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

>>> design/ntt_twiddle_generator_core.sv
// Top level of the NTT twiddle generator: registers, exponent and power sequencer.
// One request at a time: the exponent is formed on acceptance, then each root is
// raised to it by left-to-right square-and-multiply and scaled by the Montgomery
// factor, all on a single shared bit-serial modular multiplier. Each product holds
// the sequencer through an issue step, a start step, each bit of the operand a in turn
// and a result step. With EXP_W = log2(POLY_DEGREE/2) exponent bits, a root needs at
// most 2 * EXP_W products, and a modulus below 2 returns zero twiddles. POLY_DEGREE is
// taken as a power of two. The input side stalls from acceptance until the result has
// been taken.
module ntt_twiddle_generator_core
    import ntwg_pkg::*;
#(
    parameter int unsigned POLY_DEGREE = 256,
    parameter int unsigned LANES       = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FAC_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [2:0]           stage,
    input  logic [3:0]           group,
    input  logic [2:0]           lane,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [RES_W-1:0]     twiddle,
    output logic [RES_W-1:0]     inverse_twiddle,
    output logic [6:0]           exponent
);

    localparam int unsigned HALF  = POLY_DEGREE / 2;
    localparam int unsigned EXP_W = $clog2(HALF);
    localparam int unsigned BIT_W = (EXP_W > 1) ? $clog2(EXP_W) : 1;
    localparam int unsigned SUM_W = $clog2(LANES) + 13;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ,
        S_MUL,
        S_ADV,
        S_SCALE,
        S_WAIT,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        OP_SQ,
        OP_MUL,
        OP_SCALE
    } op_t;

    state_t           state_reg;
    op_t              op_reg;
    logic             sel_reg;
    logic             started_reg;
    logic [BIT_W-1:0] bit_reg;
    logic [EXP_W-1:0] exp_reg;
    logic [RES_W-1:0] acc_reg;
    logic [RES_W-1:0] tw_reg;
    logic [RES_W-1:0] itw_reg;
    logic             mm_go_reg;

    logic [RES_W-1:0] forward_root_reg;
    logic [RES_W-1:0] inverse_root_reg;
    logic [RES_W-1:0] modulus_reg;
    logic [FAC_W-1:0] montgomery_factor_reg;

    logic [SUM_W-1:0] lane_base;
    logic [SUM_W-1:0] exp_sum;
    logic             in_accept;

    logic [FAC_W-1:0] mm_a;
    logic             mm_done;
    logic [RES_W-1:0] mm_product;
    logic [RES_W-1:0] root_sel;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;

    assign lane_base = SUM_W'(LANES) << stage;
    assign exp_sum   = SUM_W'(lane_base * SUM_W'(group)) + (SUM_W'(lane) << stage);

    assign root_sel  = sel_reg ? inverse_root_reg : forward_root_reg;

    always_comb
    begin
        case (op_reg)
            OP_SQ:    mm_a = {1'b0, acc_reg};
            OP_MUL:   mm_a = {1'b0, root_sel};
            OP_SCALE: mm_a = montgomery_factor_reg;
            default:  mm_a = {1'b0, acc_reg};
        endcase
    end

    ntwg_mulmod u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mm_go_reg),
        .a       (mm_a),
        .b       (acc_reg),
        .q       (modulus_reg),
        .done    (mm_done),
        .product (mm_product)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            forward_root_reg      <= FORWARD_ROOT_RST;
            inverse_root_reg      <= INVERSE_ROOT_RST;
            modulus_reg           <= MODULUS_RST;
            montgomery_factor_reg <= MONTGOMERY_FACTOR_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FORWARD_ROOT:      forward_root_reg      <= cfg_data[RES_W-1:0];
                REG_INVERSE_ROOT:      inverse_root_reg      <= cfg_data[RES_W-1:0];
                REG_MODULUS:           modulus_reg           <= cfg_data[RES_W-1:0];
                REG_MONTGOMERY_FACTOR: montgomery_factor_reg <= cfg_data;
                default:               ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            op_reg      <= OP_SQ;
            sel_reg     <= 1'b0;
            started_reg <= 1'b0;
            bit_reg     <= '0;
            mm_go_reg   <= 1'b0;
            exp_reg     <= '0;
            acc_reg     <= '0;
            tw_reg      <= '0;
            itw_reg     <= '0;
        end
        else
        begin
            mm_go_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        exp_reg     <= exp_sum[EXP_W-1:0];
                        sel_reg     <= 1'b0;
                        started_reg <= 1'b0;
                        bit_reg     <= BIT_W'(EXP_W - 1);
                        acc_reg     <= RES_W'(1);
                        tw_reg      <= '0;
                        itw_reg     <= '0;
                        if (modulus_reg < RES_W'(2))
                            state_reg <= S_OUT;
                        else
                            state_reg <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    if (started_reg)
                    begin
                        op_reg    <= OP_SQ;
                        mm_go_reg <= 1'b1;
                        state_reg <= S_WAIT;
                    end
                    else
                    begin
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    if (exp_reg[bit_reg])
                    begin
                        op_reg    <= OP_MUL;
                        mm_go_reg <= 1'b1;
                        state_reg <= S_WAIT;
                    end
                    else
                    begin
                        state_reg <= S_ADV;
                    end
                end
                S_ADV:
                begin
                    if (bit_reg == '0)
                    begin
                        state_reg <= S_SCALE;
                    end
                    else
                    begin
                        bit_reg   <= bit_reg - 1'b1;
                        state_reg <= S_SQ;
                    end
                end
                S_SCALE:
                begin
                    op_reg    <= OP_SCALE;
                    mm_go_reg <= 1'b1;
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (mm_done)
                    begin
                        case (op_reg)
                            OP_SQ:
                            begin
                                acc_reg   <= mm_product;
                                state_reg <= S_MUL;
                            end
                            OP_MUL:
                            begin
                                acc_reg     <= mm_product;
                                started_reg <= 1'b1;
                                state_reg   <= S_ADV;
                            end
                            default:
                            begin
                                if (!sel_reg)
                                begin
                                    tw_reg      <= mm_product;
                                    sel_reg     <= 1'b1;
                                    started_reg <= 1'b0;
                                    bit_reg     <= BIT_W'(EXP_W - 1);
                                    acc_reg     <= RES_W'(1);
                                    state_reg   <= S_SQ;
                                end
                                else
                                begin
                                    itw_reg   <= mm_product;
                                    state_reg <= S_OUT;
                                end
                            end
                        endcase
                    end
                end
                S_OUT:
                begin
                    if (!out_stall)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid       = (state_reg == S_OUT);
    assign twiddle         = tw_reg;
    assign inverse_twiddle = itw_reg;
    assign exponent        = 7'(exp_reg);

endmodule

>>> dv/tb_ntt_twiddle_generator_core.sv
// Testbench for the NTT twiddle generator core: directed and random requests checked against a local model.
module tb_ntt_twiddle_generator_core;
    import ntwg_pkg::*;

    localparam int unsigned POLY_DEGREE  = 256;
    localparam int unsigned LANES        = 8;
    localparam int unsigned HALF_DEGREE  = POLY_DEGREE / 2;
    localparam int unsigned IDLE_LIMIT   = 20000;
    localparam int unsigned DRAIN_CYCLES = 1100;
    localparam int unsigned MAX_REPORTS  = 10;
    localparam int unsigned PHASES       = 8;
    localparam int unsigned PHASE_ITEMS  = 200;

    typedef struct packed {
        logic [RES_W-1:0] twiddle;
        logic [RES_W-1:0] inverse_twiddle;
        logic [6:0]       exponent;
    } twiddle_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_FORWARD_ROOT;
    logic [FAC_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [2:0]           stage = '0;
    logic [3:0]           group = '0;
    logic [2:0]           lane = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [RES_W-1:0]     twiddle;
    logic [RES_W-1:0]     inverse_twiddle;
    logic [6:0]           exponent;

    logic [RES_W-1:0]     fwd_root = FORWARD_ROOT_RST;
    logic [RES_W-1:0]     inv_root = INVERSE_ROOT_RST;
    logic [RES_W-1:0]     mod_q = MODULUS_RST;
    logic [FAC_W-1:0]     mont_r = MONTGOMERY_FACTOR_RST;

    twiddle_t             expected_twiddles[$];
    int unsigned          mismatch_count = 0;
    int unsigned          idle_cycles = 0;
    int unsigned          stall_left = 0;
    bit                   quiet = 1'b0;

    ntt_twiddle_generator_core #(
        .POLY_DEGREE (POLY_DEGREE),
        .LANES       (LANES)
    ) i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .stage           (stage),
        .group           (group),
        .lane            (lane),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .twiddle         (twiddle),
        .inverse_twiddle (inverse_twiddle),
        .exponent        (exponent)
    );

    always #4 clk = ~clk;

    function automatic longint unsigned power_mod(input longint unsigned base,
                                                  input longint unsigned e,
                                                  input longint unsigned m);
        longint unsigned acc;
        longint unsigned b;
        longint unsigned k;
        acc = 1 % m;
        b = base % m;
        k = e;
        while (k != 0)
        begin
            if (k[0])
                acc = (acc * b) % m;
            b = (b * b) % m;
            k = k >> 1;
        end
        return acc;
    endfunction

    function automatic twiddle_t predict_twiddles(input logic [2:0] s, input logic [3:0] g,
                                                  input logic [2:0] l);
        longint unsigned s_w;
        longint unsigned g_w;
        longint unsigned l_w;
        longint unsigned e;
        longint unsigned m;
        longint unsigned r;
        twiddle_t t;
        s_w = s;
        g_w = g;
        l_w = l;
        e = (((longint'(LANES) << s_w) * g_w) + (l_w << s_w)) % HALF_DEGREE;
        t.twiddle = '0;
        t.inverse_twiddle = '0;
        t.exponent = e[6:0];
        if (mod_q >= 2)
        begin
            m = mod_q;
            r = mont_r % m;
            t.twiddle = RES_W'((power_mod(fwd_root, e, m) * r) % m);
            t.inverse_twiddle = RES_W'((power_mod(inv_root, e, m) * r) % m);
        end
        return t;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        if (mismatch_count < MAX_REPORTS)
            $display("[%0t] %s: expected %h, got %h", $realtime, what, want, got);
        mismatch_count++;
    endtask

    task automatic send_request(input logic [2:0] s, input logic [3:0] g, input logic [2:0] l);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        stage <= s;
        group <= g;
        lane <= l;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_twiddles.push_back(predict_twiddles(s, g, l));
    endtask

    task automatic send_random_request();
        send_request(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                     3'($urandom_range(0, 7)));
    endtask

    task automatic drain_requests();
        in_valid <= 1'b0;
        while (expected_twiddles.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_config(input logic [FAC_W-1:0] w, input logic [FAC_W-1:0] w_inv,
                              input logic [FAC_W-1:0] q, input logic [FAC_W-1:0] r);
        logic [FAC_W-1:0] values [4];
        logic [CFG_IDX_W-1:0] idx [4];
        values = '{w, w_inv, q, r};
        idx = '{REG_FORWARD_ROOT, REG_INVERSE_ROOT, REG_MODULUS, REG_MONTGOMERY_FACTOR};
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= values[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            case (idx[i])
                REG_FORWARD_ROOT:      fwd_root = values[i][RES_W-1:0];
                REG_INVERSE_ROOT:      inv_root = values[i][RES_W-1:0];
                REG_MODULUS:           mod_q = values[i][RES_W-1:0];
                REG_MONTGOMERY_FACTOR: mont_r = values[i];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_values();
        send_request(3'd0, 4'd0, 3'd0);
        send_request(3'd7, 4'd15, 3'd7);
        send_request(3'd3, 4'd5, 3'd2);
        drain_requests();
    endtask

    task automatic test_field_extremes();
        set_config(32'd62, 32'd1115, 32'd7681, 32'd5569);
        for (int s = 0; s < 2; s++)
            for (int g = 0; g < 2; g++)
                for (int l = 0; l < 2; l++)
                    send_request(s ? 3'd7 : 3'd0, g ? 4'd15 : 4'd0, l ? 3'd7 : 3'd0);
        send_request(3'd1, 4'd1, 3'd1);
        drain_requests();
    endtask

    task automatic test_special_cases();
        // zero and unit modulus
        set_config(32'd5, 32'd7, 32'd0, 32'd262144);
        send_request(3'd0, 4'd3, 3'd1);
        send_request(3'd7, 4'd15, 3'd7);
        drain_requests();
        set_config(32'd5, 32'd7, 32'd1, 32'd262144);
        send_request(3'd2, 4'd9, 3'd6);
        drain_requests();
        // roots and factor above the modulus, upper data bit set
        set_config(32'hFFFF_FFFF, 32'h8000_1234, 32'h8000_0061, 32'hFFFF_FFFF);
        send_request(3'd1, 4'd7, 3'd3);
        send_request(3'd0, 4'd15, 3'd7);
        drain_requests();
        // widest modulus with zero factor, then widest factor
        set_config(32'd2147483646, 32'd2147483645, 32'd2147483647, 32'd0);
        send_request(3'd0, 4'd15, 3'd7);
        send_request(3'd4, 4'd1, 3'd0);
        drain_requests();
        set_config(32'd2147483646, 32'd2147483645, 32'd2147483647, 32'hFFFF_FFFF);
        send_request(3'd0, 4'd15, 3'd7);
        send_request(3'd0, 4'd0, 3'd0);
        drain_requests();
    endtask

    task automatic test_random_requests();
        logic [FAC_W-1:0] q;
        for (int p = 0; p < PHASES; p++)
        begin
            case ($urandom_range(0, 9))
                0:       q = $urandom_range(0, 1);
                1:       q = {1'($urandom_range(0, 1)), 31'h7FFF_FFFF};
                2, 3, 4: q = $urandom_range(2, 65535);
                default: q = $urandom;
            endcase
            set_config($urandom, $urandom, q, $urandom);
            if (p == PHASES - 1)
                quiet = 1'b1;
            repeat (PHASE_ITEMS) send_random_request();
            drain_requests();
        end
    endtask

    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 5);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : check_results
        twiddle_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_twiddles.size() == 0)
            begin
                report_mismatch("result with nothing pending", '0, 32'(twiddle));
            end
            else
            begin
                want = expected_twiddles.pop_front();
                if (twiddle !== want.twiddle)
                    report_mismatch("twiddle", 32'(want.twiddle), 32'(twiddle));
                if (inverse_twiddle !== want.inverse_twiddle)
                    report_mismatch("inverse_twiddle", 32'(want.inverse_twiddle),
                                    32'(inverse_twiddle));
                if (exponent !== want.exponent)
                    report_mismatch("exponent", 32'(want.exponent), 32'(exponent));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[%0t] watchdog: no item moved for %0d cycles", $realtime, IDLE_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_field_extremes();
        test_special_cases();
        test_random_requests();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
